// ===== src/ptob_pkg.sv =====
package ptob_pkg;

    localparam int DEF_SIDE_DEPTH = 32;
    localparam int DEF_PRICE_BITS = 32;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_CANCEL  = 2'd1;
    localparam logic [1:0] OP_POP_BID = 2'd2;
    localparam logic [1:0] OP_POP_ASK = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] order_id;
        logic [31:0] price;
        logic        is_buy;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] popped_id;
        logic [31:0] popped_price;
        logic        best_bid_valid;
        logic [63:0] best_bid_id;
        logic [31:0] best_bid_price;
        logic        best_ask_valid;
        logic [63:0] best_ask_id;
        logic [31:0] best_ask_price;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic compare;
        logic apply;
    } t_ctrl;

    typedef struct packed {
        logic out_valid;
    } t_stat;

endpackage

// ===== src/ptob_ctrl.sv =====
module ptob_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  ptob_pkg::t_stat i_stat,
    output ptob_pkg::t_ctrl o_ctrl
);
    import ptob_pkg::*;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_APPLY   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_in_ready = (r_state == S_IDLE);
        o_ctrl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state = S_COMPARE;
                end
            end
            S_COMPARE: begin
                o_ctrl.compare = 1'b1;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (!i_stat.out_valid || i_out_ready) begin
                    o_ctrl.apply = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/ptob_datapath.sv =====
module ptob_datapath #(
    parameter int SIDE_DEPTH = ptob_pkg::DEF_SIDE_DEPTH,
    parameter int PRICE_BITS = ptob_pkg::DEF_PRICE_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptob_pkg::t_req  i_req,
    input  ptob_pkg::t_ctrl i_ctrl,
    input  logic            i_out_ready,
    output ptob_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output ptob_pkg::t_rsp  o_rsp
);
    import ptob_pkg::*;

    localparam int CW = $clog2(SIDE_DEPTH + 1);
    localparam int LW = $clog2(SIDE_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(SIDE_DEPTH);

    t_req r_req;
    logic [63:0]         r_bid_id [SIDE_DEPTH];
    logic [PRICE_BITS-1:0] r_bid_px [SIDE_DEPTH];
    logic [63:0]         r_ask_id [SIDE_DEPTH];
    logic [PRICE_BITS-1:0] r_ask_px [SIDE_DEPTH];
    logic [CW-1:0]       r_bid_cnt, r_ask_cnt;
    logic [SIDE_DEPTH-1:0] r_ahead_b, r_ahead_a, r_match_b, r_match_a;
    logic r_out_valid;
    t_rsp r_rsp;

    logic [63:0]         n_bid_id [SIDE_DEPTH];
    logic [PRICE_BITS-1:0] n_bid_px [SIDE_DEPTH];
    logic [63:0]         n_ask_id [SIDE_DEPTH];
    logic [PRICE_BITS-1:0] n_ask_px [SIDE_DEPTH];
    logic [CW-1:0]       n_bid_cnt, n_ask_cnt;
    t_rsp n_rsp;

    logic [PRICE_BITS-1:0] req_px;
    logic [SIDE_DEPTH-1:0] n_ahead_b, n_ahead_a, n_match_b, n_match_a;
    logic [SIDE_DEPTH-1:0] rm_b, rm_a, pre_b, pre_a;
    logic ins_b, ins_a, del_b, del_a;

    assign req_px = PRICE_BITS'(r_req.price);

    always_comb begin
        for (int k = 0; k < SIDE_DEPTH; k++) begin
            n_ahead_b[k] = (CW'(k) < r_bid_cnt) && (r_bid_px[k] >= req_px);
            n_ahead_a[k] = (CW'(k) < r_ask_cnt) && (r_ask_px[k] <= req_px);
            n_match_b[k] = (CW'(k) < r_bid_cnt) && (r_bid_id[k] == r_req.order_id);
            n_match_a[k] = (CW'(k) < r_ask_cnt) && (r_ask_id[k] == r_req.order_id);
        end
    end

    always_comb begin
        n_rsp = '0;
        ins_b = 1'b0;
        ins_a = 1'b0;
        del_b = 1'b0;
        del_a = 1'b0;
        rm_b = '0;
        rm_a = '0;
        case (r_req.operation)
            OP_ADD: begin
                if (r_req.is_buy) begin
                    if (r_bid_cnt < FULL) ins_b = 1'b1;
                    else n_rsp.status = ST_FULL;
                end else begin
                    if (r_ask_cnt < FULL) ins_a = 1'b1;
                    else n_rsp.status = ST_FULL;
                end
            end
            OP_CANCEL: begin
                if (|r_match_b) begin
                    del_b = 1'b1;
                    rm_b = r_match_b;
                end else if (|r_match_a) begin
                    del_a = 1'b1;
                    rm_a = r_match_a;
                end else begin
                    n_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_POP_BID: begin
                if (r_bid_cnt != '0) begin
                    del_b = 1'b1;
                    rm_b = SIDE_DEPTH'(1);
                    n_rsp.popped_id = r_bid_id[0];
                    n_rsp.popped_price = 32'(r_bid_px[0]);
                end else begin
                    n_rsp.status = ST_EMPTY;
                end
            end
            OP_POP_ASK: begin
                if (r_ask_cnt != '0) begin
                    del_a = 1'b1;
                    rm_a = SIDE_DEPTH'(1);
                    n_rsp.popped_id = r_ask_id[0];
                    n_rsp.popped_price = 32'(r_ask_px[0]);
                end else begin
                    n_rsp.status = ST_EMPTY;
                end
            end
            default: n_rsp.status = ST_DONE;
        endcase

        pre_b = rm_b;
        pre_a = rm_a;
        for (int s = 0; s <= LW; s++) begin
            pre_b = pre_b | (pre_b << (1 << s));
            pre_a = pre_a | (pre_a << (1 << s));
        end

        n_bid_cnt = r_bid_cnt;
        n_ask_cnt = r_ask_cnt;
        for (int k = 0; k < SIDE_DEPTH; k++) begin
            n_bid_id[k] = r_bid_id[k];
            n_bid_px[k] = r_bid_px[k];
            n_ask_id[k] = r_ask_id[k];
            n_ask_px[k] = r_ask_px[k];
        end
        if (ins_b) begin
            n_bid_cnt = r_bid_cnt + CW'(1);
            if (!r_ahead_b[0]) begin
                n_bid_id[0] = r_req.order_id;
                n_bid_px[0] = req_px;
            end
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                if (!r_ahead_b[k]) begin
                    n_bid_id[k] = r_ahead_b[k-1] ? r_req.order_id : r_bid_id[k-1];
                    n_bid_px[k] = r_ahead_b[k-1] ? req_px : r_bid_px[k-1];
                end
            end
        end
        if (ins_a) begin
            n_ask_cnt = r_ask_cnt + CW'(1);
            if (!r_ahead_a[0]) begin
                n_ask_id[0] = r_req.order_id;
                n_ask_px[0] = req_px;
            end
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                if (!r_ahead_a[k]) begin
                    n_ask_id[k] = r_ahead_a[k-1] ? r_req.order_id : r_ask_id[k-1];
                    n_ask_px[k] = r_ahead_a[k-1] ? req_px : r_ask_px[k-1];
                end
            end
        end
        if (del_b) begin
            n_bid_cnt = r_bid_cnt - CW'(1);
            for (int k = 0; k < SIDE_DEPTH - 1; k++) begin
                if (pre_b[k]) begin
                    n_bid_id[k] = r_bid_id[k+1];
                    n_bid_px[k] = r_bid_px[k+1];
                end
            end
        end
        if (del_a) begin
            n_ask_cnt = r_ask_cnt - CW'(1);
            for (int k = 0; k < SIDE_DEPTH - 1; k++) begin
                if (pre_a[k]) begin
                    n_ask_id[k] = r_ask_id[k+1];
                    n_ask_px[k] = r_ask_px[k+1];
                end
            end
        end

        if (n_bid_cnt != '0) begin
            n_rsp.best_bid_valid = 1'b1;
            n_rsp.best_bid_id = n_bid_id[0];
            n_rsp.best_bid_price = 32'(n_bid_px[0]);
        end
        if (n_ask_cnt != '0) begin
            n_rsp.best_ask_valid = 1'b1;
            n_rsp.best_ask_id = n_ask_id[0];
            n_rsp.best_ask_price = 32'(n_ask_px[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_req <= i_req;
        end
        if (i_ctrl.compare) begin
            r_ahead_b <= n_ahead_b;
            r_ahead_a <= n_ahead_a;
            r_match_b <= n_match_b;
            r_match_a <= n_match_a;
        end
        if (i_ctrl.apply) begin
            r_rsp <= n_rsp;
            for (int k = 0; k < SIDE_DEPTH; k++) begin
                r_bid_id[k] <= n_bid_id[k];
                r_bid_px[k] <= n_bid_px[k];
                r_ask_id[k] <= n_ask_id[k];
                r_ask_px[k] <= n_ask_px[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid_cnt <= '0;
            r_ask_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.apply) begin
                r_bid_cnt <= n_bid_cnt;
                r_ask_cnt <= n_ask_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_rsp = r_rsp;

endmodule

// ===== src/price_time_order_book.sv =====
// Price-time priority order book. Each request adds, cancels or pops an order and
// yields one response carrying the status and the best bid and ask after the request.
// A request moves from acceptance to its response through a capture step, a registered
// price compare and id match across every resting entry, and an update step that shifts
// the sorted entry rows and loads the response register. The next request is accepted
// in the cycle after that update, so the book takes no new request before the last one
// is through; a held response stalls only the update step.
module price_time_order_book #(
    parameter int SIDE_DEPTH = ptob_pkg::DEF_SIDE_DEPTH,
    parameter int PRICE_BITS = ptob_pkg::DEF_PRICE_BITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptob_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ptob_pkg::t_rsp o_out_data
);
    import ptob_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    ptob_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    ptob_datapath #(
        .SIDE_DEPTH (SIDE_DEPTH),
        .PRICE_BITS (PRICE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_ctrl      (ctrl),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_rsp       (o_out_data)
    );

endmodule

// ===== src/ptob_checker.sv =====
module ptob_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input ptob_pkg::t_req i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input ptob_pkg::t_rsp o_out_data
);
    import ptob_pkg::*;

    a_bid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.best_bid_valid) |->
        (o_out_data.best_bid_id == '0 && o_out_data.best_bid_price == '0))
        else $error("empty bid side reports a nonzero best bid");

    a_ask_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.best_ask_valid) |->
        (o_out_data.best_ask_id == '0 && o_out_data.best_ask_price == '0))
        else $error("empty ask side reports a nonzero best ask");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled response changed");

endmodule

bind price_time_order_book ptob_checker u_ptob_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== verif/price_time_order_book_tb.sv =====
`timescale 1ns / 100ps

module price_time_order_book_tb;
    import ptob_pkg::*;

    localparam int DEPTH = DEF_SIDE_DEPTH;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM = 1900;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_req i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_rsp o_out_data;

    price_time_order_book u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    logic [63:0] bid_ids [DEPTH];
    logic [31:0] bid_px [DEPTH];
    int bid_cnt;
    logic [63:0] ask_ids [DEPTH];
    logic [31:0] ask_px [DEPTH];
    int ask_cnt;

    t_rsp rsp_pending [$];
    logic fixed_pending [$];
    int fail_count;
    int watchdog;
    logic quiet_phase;
    logic [63:0] recent_ids [$];

    typedef struct {
        t_req req;
        logic has_fixed;
        t_rsp fixed;
    } t_row;

    t_row rows [$];

    function automatic void add_row(input t_req req, input logic has_fixed,
                                    input t_rsp fixed);
        t_row row_v;
        row_v.req = req;
        row_v.has_fixed = has_fixed;
        row_v.fixed = fixed;
        rows.insert(rows.size(), row_v);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic t_rsp book_apply(input t_req r);
        t_rsp o;
        int pos;
        int k;
        int found;
        o = '0;
        case (r.operation)
            OP_ADD: begin
                if (r.is_buy) begin
                    if (bid_cnt >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < bid_cnt && bid_px[pos] >= r.price) pos++;
                        for (k = bid_cnt; k > pos; k--) begin
                            bid_ids[k] = bid_ids[k-1];
                            bid_px[k] = bid_px[k-1];
                        end
                        bid_ids[pos] = r.order_id;
                        bid_px[pos] = r.price;
                        bid_cnt++;
                    end
                end else begin
                    if (ask_cnt >= DEPTH) begin
                        o.status = ST_FULL;
                    end else begin
                        pos = 0;
                        while (pos < ask_cnt && ask_px[pos] <= r.price) pos++;
                        for (k = ask_cnt; k > pos; k--) begin
                            ask_ids[k] = ask_ids[k-1];
                            ask_px[k] = ask_px[k-1];
                        end
                        ask_ids[pos] = r.order_id;
                        ask_px[pos] = r.price;
                        ask_cnt++;
                    end
                end
            end
            OP_CANCEL: begin
                found = -1;
                for (k = 0; k < bid_cnt && found < 0; k++) begin
                    if (bid_ids[k] == r.order_id) found = k;
                end
                if (found >= 0) begin
                    for (k = found; k + 1 < bid_cnt; k++) begin
                        bid_ids[k] = bid_ids[k+1];
                        bid_px[k] = bid_px[k+1];
                    end
                    bid_cnt--;
                end else begin
                    for (k = 0; k < ask_cnt && found < 0; k++) begin
                        if (ask_ids[k] == r.order_id) found = k;
                    end
                    if (found >= 0) begin
                        for (k = found; k + 1 < ask_cnt; k++) begin
                            ask_ids[k] = ask_ids[k+1];
                            ask_px[k] = ask_px[k+1];
                        end
                        ask_cnt--;
                    end else begin
                        o.status = ST_NOT_FOUND;
                    end
                end
            end
            OP_POP_BID: begin
                if (bid_cnt == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.popped_id = bid_ids[0];
                    o.popped_price = bid_px[0];
                    for (k = 0; k + 1 < bid_cnt; k++) begin
                        bid_ids[k] = bid_ids[k+1];
                        bid_px[k] = bid_px[k+1];
                    end
                    bid_cnt--;
                end
            end
            default: begin
                if (ask_cnt == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.popped_id = ask_ids[0];
                    o.popped_price = ask_px[0];
                    for (k = 0; k + 1 < ask_cnt; k++) begin
                        ask_ids[k] = ask_ids[k+1];
                        ask_px[k] = ask_px[k+1];
                    end
                    ask_cnt--;
                end
            end
        endcase
        if (bid_cnt > 0) begin
            o.best_bid_valid = 1'b1;
            o.best_bid_id = bid_ids[0];
            o.best_bid_price = bid_px[0];
        end
        if (ask_cnt > 0) begin
            o.best_ask_valid = 1'b1;
            o.best_ask_id = ask_ids[0];
            o.best_ask_price = ask_px[0];
        end
        return o;
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic [63:0] id,
                                      input logic [31:0] px, input logic buy);
        t_req r;
        r.operation = op;
        r.order_id = id;
        r.price = px;
        r.is_buy = buy;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_price();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return 32'd1000 + $urandom_range(0, 15);
        endcase
    endfunction

    function automatic logic [63:0] pick_id();
        if (recent_ids.size() > 0 && $urandom_range(0, 3) != 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        return rand64();
    endfunction

    function automatic t_req random_req(input int phase);
        logic [1:0] op;
        int roll;
        roll = $urandom_range(0, 99);
        if (phase == 0) begin
            op = roll < 60 ? OP_ADD : roll < 80 ? OP_CANCEL : roll < 90 ? OP_POP_BID : OP_POP_ASK;
        end else if (phase == 1) begin
            op = roll < 15 ? OP_ADD : roll < 45 ? OP_CANCEL : roll < 72 ? OP_POP_BID : OP_POP_ASK;
        end else begin
            op = roll < 40 ? OP_ADD : roll < 65 ? OP_CANCEL : roll < 83 ? OP_POP_BID : OP_POP_ASK;
        end
        return make_req(op, op == OP_ADD ? ($urandom_range(0, 5) == 0 ? pick_id() : rand64())
                                         : pick_id(),
                        rand_price(), 1'($urandom_range(0, 1)));
    endfunction

    task automatic send_req(input t_req r, input logic has_fixed, input t_rsp fixed);
        while (!quiet_phase && $urandom_range(0, 99) < 8) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (r.operation == OP_ADD) begin
            recent_ids.insert(recent_ids.size(), r.order_id);
            if (recent_ids.size() > 48) void'(recent_ids.pop_front());
        end
        if (has_fixed) begin
            rsp_pending.insert(rsp_pending.size(), fixed);
            void'(book_apply(r));
        end else begin
            rsp_pending.insert(rsp_pending.size(), book_apply(r));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_pending.size() == 0) begin
                report_mismatch("unexpected response", 64'd0, 64'd0);
            end else begin
                want = rsp_pending.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.popped_id !== want.popped_id)
                    report_mismatch("popped_id", o_out_data.popped_id, want.popped_id);
                if (o_out_data.popped_price !== want.popped_price)
                    report_mismatch("popped_price", o_out_data.popped_price, want.popped_price);
                if (o_out_data.best_bid_valid !== want.best_bid_valid)
                    report_mismatch("best_bid_valid", o_out_data.best_bid_valid,
                                    want.best_bid_valid);
                if (o_out_data.best_bid_id !== want.best_bid_id)
                    report_mismatch("best_bid_id", o_out_data.best_bid_id, want.best_bid_id);
                if (o_out_data.best_bid_price !== want.best_bid_price)
                    report_mismatch("best_bid_price", o_out_data.best_bid_price,
                                    want.best_bid_price);
                if (o_out_data.best_ask_valid !== want.best_ask_valid)
                    report_mismatch("best_ask_valid", o_out_data.best_ask_valid,
                                    want.best_ask_valid);
                if (o_out_data.best_ask_id !== want.best_ask_id)
                    report_mismatch("best_ask_id", o_out_data.best_ask_id, want.best_ask_id);
                if (o_out_data.best_ask_price !== want.best_ask_price)
                    report_mismatch("best_ask_price", o_out_data.best_ask_price,
                                    want.best_ask_price);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("price_time_order_book_tb NOT OK");
                $finish;
            end
        end
    end

    initial begin
        t_rsp fx;
        t_row row;
        int n;
        int phase;
        fail_count = 0;
        watchdog = 0;
        bid_cnt = 0;
        ask_cnt = 0;
        quiet_phase = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;

        fx = '0;
        fx.status = ST_EMPTY;
        add_row(make_req(OP_POP_BID, 64'd0, 32'd0, 1'b0), 1'b1, fx);
        add_row(make_req(OP_POP_ASK, '1, '1, 1'b1), 1'b1, fx);
        fx.status = ST_NOT_FOUND;
        add_row(make_req(OP_CANCEL, 64'h1234, 32'd0, 1'b0), 1'b1, fx);
        fx = '0;
        fx.best_bid_valid = 1'b1;
        fx.best_bid_id = '1;
        fx.best_bid_price = '1;
        add_row(make_req(OP_ADD, '1, '1, 1'b1), 1'b1, fx);
        fx.best_ask_valid = 1'b1;
        fx.best_ask_id = 64'd0;
        fx.best_ask_price = 32'd0;
        add_row(make_req(OP_ADD, 64'd0, 32'd0, 1'b0), 1'b1, fx);
        add_row(make_req(OP_ADD, 64'd7, 32'd50, 1'b1), 1'b0, '0);
        add_row(make_req(OP_ADD, 64'd8, 32'd50, 1'b1), 1'b0, '0);
        add_row(make_req(OP_ADD, 64'd9, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_ADD, 64'd7, 32'd60, 1'b0), 1'b0, '0);
        add_row(make_req(OP_CANCEL, 64'd7, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_CANCEL, 64'd7, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_BID, 64'd0, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_BID, 64'd0, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_ASK, 64'd0, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_ASK, 64'd0, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_ASK, 64'd0, 32'd0, 1'b0), 1'b0, '0);
        add_row(make_req(OP_POP_BID, 64'd0, 32'd0, 1'b0), 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            row = rows[i];
            send_req(row.req, row.has_fixed, row.fixed);
        end

        for (n = 0; n < 2 * DEPTH + 4; n++)
            send_req(make_req(OP_ADD, rand64(), rand_price(), n[0]), 1'b0, '0);

        for (n = 0; n < NUM_RANDOM; n++) begin
            phase = (n / 150) % 3;
            quiet_phase = (n >= 600 && n < 800);
            if (n == 300 || n == 1200) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (rsp_pending.size() != 0) @(posedge i_clk);
            end
            send_req(random_req(phase), 1'b0, '0);
        end
        quiet_phase = 1'b0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (rsp_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && rsp_pending.size() == 0) begin
            $display("price_time_order_book_tb OK");
        end else begin
            $display("price_time_order_book_tb NOT OK");
        end
        $finish;
    end

endmodule
